>>> src/rtp_rtx_to_original_rewriter_macros.svh
`ifndef RTP_RTX_TO_ORIGINAL_REWRITER_MACROS_SVH
`define RTP_RTX_TO_ORIGINAL_REWRITER_MACROS_SVH

// same-cycle implication, reset disables
`define RRW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, no reset disable
`define RRW_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/rrw_pkg.sv
package rrw_pkg;

  localparam int MAX_EXT_WORDS_DEF = 8;
  localparam int APT_ENTRIES_DEF   = 4;
  localparam int FID_ENTRIES_DEF   = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_APT_MAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FID_PAIR0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FID_PAIR3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FID_COUNT = 3'd5;

  localparam int APT_ENTRY_W = 15;
  localparam int APT_MAP_W   = 60;

  localparam logic [7:0] RTCP_PT_LO = 8'd194;
  localparam logic [7:0] RTCP_PT_HI = 8'd223;

endpackage

>>> src/rrw_if.sv
interface rrw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface rrw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       run_end;
  logic       rewritten;
  modport source (output valid, out_byte, out_last, run_end, rewritten, input ready);
  modport sink   (input valid, out_byte, out_last, run_end, rewritten, output ready);
endinterface

interface rrw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/rrw_ram.sv
module rrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/rtp_rtx_to_original_rewriter.sv
// Pass-through bytes: one input beat per cycle while the output is free, result registered
// in the cycle after. Header bytes after the first go to a 16+4*MAX_EXT_WORDS byte store and
// produce no result until the header is decided; the flush then reads the store with a read
// and a data state per byte (single-port store, registered read), holding off input.
// Reset (rst_n low, synchronous) returns to start of packet and clears config, control state
// and the output beat; data registers and the store are not cleared, each is written first.
module rtp_rtx_to_original_rewriter
  import rrw_pkg::*;
#(
  parameter int MAX_EXT_WORDS = MAX_EXT_WORDS_DEF,
  parameter int APT_ENTRIES   = APT_ENTRIES_DEF,
  parameter int FID_ENTRIES   = FID_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rrw_in_if.sink     in_s,
  rrw_out_if.source  out_m,
  rrw_cfg_if.sink    cfg_s
);

  localparam int DEPTH = 16 + 4 * MAX_EXT_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 2);
  localparam int EW    = $clog2(MAX_EXT_WORDS + 2);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_HDR     = 3'd1;
  localparam logic [2:0] PH_EXTHDR  = 3'd2;
  localparam logic [2:0] PH_EXT     = 3'd3;
  localparam logic [2:0] PH_OSN     = 3'd4;
  localparam logic [2:0] PH_PASS    = 3'd5;
  localparam logic [2:0] PH_PASS_RW = 3'd6;

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_RD   = 2'd1;
  localparam logic [1:0] SQ_DAT  = 2'd2;
  localparam logic [1:0] SQ_XTRA = 2'd3;

  logic [APT_MAP_W-1:0] apt_r;
  logic [63:0]          fid_r [FID_ENTRIES];
  logic [2:0]           fcnt_r;

  logic [2:0]    phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          ext0_r, ext0_nxt;
  logic [7:0]    b1_r, b1_nxt;
  logic [23:0]   ssrc_r, ssrc_nxt;
  logic [7:0]    lenhi_r, lenhi_nxt;
  logic [EW-1:0] extw_r, extw_nxt;
  logic [6:0]    map_r, map_nxt;
  logic [31:0]   orig_r, orig_nxt;
  logic [7:0]    osnhi_r, osnhi_nxt;
  logic [7:0]    osnlo_r, osnlo_nxt;

  logic [1:0]    seq_r, seq_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic          fl_last_r, fl_last_nxt;
  logic          fl_rw_r, fl_rw_nxt;
  logic          xtra_r, xtra_nxt;
  logic [7:0]    xb_r, xb_nxt;
  logic          xl_r, xl_nxt;

  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic          ore_r, ore_nxt;
  logic          orw_r, orw_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  logic          slot_free, acc;
  logic          apt_hit, fid_hit;
  logic [6:0]    apt_mapped;
  logic [31:0]   fid_orig;
  logic [31:0]   ssrc_full;
  logic [2:0]    fid_lim;
  logic [15:0]   ext_len;
  logic [PW-1:0] hl;
  logic [PW-1:0] ext_last;
  logic [7:0]    sub_byte;

  rrw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_s.in_byte),
    .rdata (ram_rdata)
  );

  assign slot_free   = !ov_r || out_m.ready;
  assign in_s.ready  = (seq_r == SQ_IDLE) && slot_free;
  assign acc         = in_s.valid && in_s.ready;
  assign cfg_s.ready = 1'b1;

  assign out_m.valid     = ov_r;
  assign out_m.out_byte  = ob_r;
  assign out_m.out_last  = ol_r;
  assign out_m.run_end   = ore_r;
  assign out_m.rewritten = orw_r;

  assign ssrc_full = {ssrc_r, in_s.in_byte};
  assign fid_lim   = (fcnt_r > 3'(FID_ENTRIES)) ? 3'(FID_ENTRIES) : fcnt_r;
  assign ext_len   = {lenhi_r, in_s.in_byte};
  assign hl        = ext0_r ? (PW'({extw_r, 2'b00}) + PW'(16)) : PW'(12);
  assign ext_last  = PW'({extw_r, 2'b00}) + PW'(15);

  always_comb begin
    apt_hit    = 1'b0;
    apt_mapped = '0;
    for (int i = APT_ENTRIES - 1; i >= 0; i--) begin
      if (apt_r[APT_ENTRY_W*i+14] && (apt_r[APT_ENTRY_W*i+7 +: 7] == b1_r[6:0])) begin
        apt_hit    = 1'b1;
        apt_mapped = apt_r[APT_ENTRY_W*i +: 7];
      end
    end
  end

  always_comb begin
    fid_hit  = 1'b0;
    fid_orig = '0;
    for (int i = FID_ENTRIES - 1; i >= 0; i--) begin
      if ((3'(i) < fid_lim) && (fid_r[i][31:0] == ssrc_full)) begin
        fid_hit  = 1'b1;
        fid_orig = fid_r[i][63:32];
      end
    end
  end

  always_comb begin
    case (idx_r)
      AW'(1):  sub_byte = {b1_r[7], map_r};
      AW'(2):  sub_byte = osnhi_r;
      AW'(3):  sub_byte = osnlo_r;
      AW'(8):  sub_byte = orig_r[31:24];
      AW'(9):  sub_byte = orig_r[23:16];
      AW'(10): sub_byte = orig_r[15:8];
      AW'(11): sub_byte = orig_r[7:0];
      default: sub_byte = ram_rdata;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    ext0_nxt    = ext0_r;
    b1_nxt      = b1_r;
    ssrc_nxt    = ssrc_r;
    lenhi_nxt   = lenhi_r;
    extw_nxt    = extw_r;
    map_nxt     = map_r;
    orig_nxt    = orig_r;
    osnhi_nxt   = osnhi_r;
    osnlo_nxt   = osnlo_r;
    seq_nxt     = seq_r;
    idx_nxt     = idx_r;
    end_nxt     = end_r;
    fl_last_nxt = fl_last_r;
    fl_rw_nxt   = fl_rw_r;
    xtra_nxt    = xtra_r;
    xb_nxt      = xb_r;
    xl_nxt      = xl_r;
    ov_nxt      = ov_r && !out_m.ready;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    ore_nxt     = ore_r;
    orw_nxt     = orw_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = idx_r;

    case (seq_r)
      SQ_IDLE: begin
        if (acc) begin
          case (phase_r)
            PH_START: begin
              ext0_nxt  = in_s.in_byte[4];
              extw_nxt  = '0;
              ov_nxt    = 1'b1;
              ob_nxt    = in_s.in_byte;
              ol_nxt    = in_s.in_last;
              ore_nxt   = 1'b1;
              orw_nxt   = 1'b0;
              phase_nxt = PH_HDR;
              pos_nxt   = PW'(1);
            end
            PH_HDR, PH_EXTHDR, PH_EXT: begin
              ram_we   = 1'b1;
              ram_addr = pos_r[AW-1:0];
              pos_nxt  = pos_r + PW'(1);
              if (in_s.in_last) begin
                seq_nxt     = SQ_RD;
                idx_nxt     = AW'(1);
                end_nxt     = pos_r[AW-1:0];
                fl_last_nxt = 1'b1;
                fl_rw_nxt   = 1'b0;
                xtra_nxt    = 1'b0;
              end else if (phase_r == PH_HDR) begin
                if (pos_r == PW'(1)) begin
                  b1_nxt = in_s.in_byte;
                  if (in_s.in_byte inside {[RTCP_PT_LO:RTCP_PT_HI]}) begin
                    ov_nxt    = 1'b1;
                    ob_nxt    = in_s.in_byte;
                    ol_nxt    = 1'b0;
                    ore_nxt   = 1'b1;
                    orw_nxt   = 1'b0;
                    phase_nxt = PH_PASS;
                  end
                end else if (pos_r inside {PW'(8), PW'(9), PW'(10)}) begin
                  ssrc_nxt = {ssrc_r[15:0], in_s.in_byte};
                end else if (pos_r == PW'(11)) begin
                  if (apt_hit && fid_hit) begin
                    map_nxt   = apt_mapped;
                    orig_nxt  = fid_orig;
                    phase_nxt = ext0_r ? PH_EXTHDR : PH_OSN;
                  end else begin
                    seq_nxt     = SQ_RD;
                    idx_nxt     = AW'(1);
                    end_nxt     = AW'(11);
                    fl_last_nxt = 1'b0;
                    fl_rw_nxt   = 1'b0;
                    xtra_nxt    = 1'b0;
                    phase_nxt   = PH_PASS;
                  end
                end
              end else if (phase_r == PH_EXTHDR) begin
                if (pos_r == PW'(14)) begin
                  lenhi_nxt = in_s.in_byte;
                end else if (pos_r == PW'(15)) begin
                  if (ext_len > 16'(MAX_EXT_WORDS)) begin
                    seq_nxt     = SQ_RD;
                    idx_nxt     = AW'(1);
                    end_nxt     = AW'(15);
                    fl_last_nxt = 1'b0;
                    fl_rw_nxt   = 1'b0;
                    xtra_nxt    = 1'b0;
                    phase_nxt   = PH_PASS;
                  end else begin
                    extw_nxt  = ext_len[EW-1:0];
                    phase_nxt = (ext_len == 16'd0) ? PH_OSN : PH_EXT;
                  end
                end
              end else begin
                if (pos_r >= ext_last) begin
                  phase_nxt = PH_OSN;
                end
              end
            end
            PH_OSN: begin
              seq_nxt   = SQ_RD;
              idx_nxt   = AW'(1);
              end_nxt   = AW'(hl - PW'(1));
              xb_nxt    = in_s.in_byte;
              xl_nxt    = in_s.in_last;
              if (pos_r == hl) begin
                osnhi_nxt = in_s.in_byte;
                if (in_s.in_last) begin
                  fl_last_nxt = 1'b0;
                  fl_rw_nxt   = 1'b0;
                  xtra_nxt    = 1'b1;
                end else begin
                  seq_nxt = SQ_IDLE;
                  pos_nxt = pos_r + PW'(1);
                end
              end else begin
                osnlo_nxt   = in_s.in_byte;
                fl_last_nxt = in_s.in_last;
                fl_rw_nxt   = 1'b1;
                xtra_nxt    = 1'b0;
                phase_nxt   = PH_PASS_RW;
              end
            end
            default: begin
              ov_nxt  = 1'b1;
              ob_nxt  = in_s.in_byte;
              ol_nxt  = in_s.in_last;
              ore_nxt = 1'b1;
              orw_nxt = (phase_r == PH_PASS_RW);
            end
          endcase
          if (in_s.in_last) begin
            phase_nxt = PH_START;
            pos_nxt   = '0;
          end
        end
      end
      SQ_RD: begin
        ram_re  = 1'b1;
        seq_nxt = SQ_DAT;
      end
      SQ_DAT: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = fl_rw_r ? sub_byte : ram_rdata;
          ol_nxt  = fl_last_r && (idx_r == end_r);
          ore_nxt = (idx_r == end_r) && !xtra_r;
          orw_nxt = fl_rw_r;
          if (idx_r == end_r) begin
            seq_nxt = xtra_r ? SQ_XTRA : SQ_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            seq_nxt = SQ_RD;
          end
        end
      end
      default: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = xb_r;
          ol_nxt  = xl_r;
          ore_nxt = 1'b1;
          orw_nxt = 1'b0;
          seq_nxt = SQ_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apt_r  <= '0;
      fcnt_r <= '0;
      for (int i = 0; i < FID_ENTRIES; i++) begin
        fid_r[i] <= '0;
      end
    end else if (cfg_s.valid) begin
      if (cfg_s.index == CFG_APT_MAP) begin
        apt_r <= cfg_s.data[APT_MAP_W-1:0];
      end else if (cfg_s.index == CFG_FID_COUNT) begin
        fcnt_r <= cfg_s.data[2:0];
      end else if (cfg_s.index >= CFG_FID_PAIR0 && cfg_s.index <= CFG_FID_PAIR3) begin
        for (int i = 0; i < FID_ENTRIES; i++) begin
          if (cfg_s.index == CFG_FID_PAIR0 + 3'(i)) begin
            fid_r[i] <= cfg_s.data;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      pos_r   <= '0;
      ext0_r  <= 1'b0;
      extw_r  <= '0;
      seq_r   <= SQ_IDLE;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ext0_r  <= ext0_nxt;
      extw_r  <= extw_nxt;
      seq_r   <= seq_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b1_r      <= b1_nxt;
    ssrc_r    <= ssrc_nxt;
    lenhi_r   <= lenhi_nxt;
    map_r     <= map_nxt;
    orig_r    <= orig_nxt;
    osnhi_r   <= osnhi_nxt;
    osnlo_r   <= osnlo_nxt;
    idx_r     <= idx_nxt;
    end_r     <= end_nxt;
    fl_last_r <= fl_last_nxt;
    fl_rw_r   <= fl_rw_nxt;
    xtra_r    <= xtra_nxt;
    xb_r      <= xb_nxt;
    xl_r      <= xl_nxt;
    ob_r      <= ob_nxt;
    ol_r      <= ol_nxt;
    ore_r     <= ore_nxt;
    orw_r     <= orw_nxt;
  end

endmodule

>>> src/rrw_chk.sv
`include "rtp_rtx_to_original_rewriter_macros.svh"

module rrw_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       run_end,
  input logic       in_ready
);

  // a stalled beat keeps its payload
  `RRW_ASSERT_IMPL(a_out_hold, clk, rst_n, $past(out_valid && !out_ready) && rst_n && $past(rst_n), out_valid && $stable(out_byte) && $stable(out_last))

  // packet end always closes the run of results
  `RRW_ASSERT_IMPL(a_last_run_end, clk, rst_n, out_valid && out_last, run_end)

  // reset drops the output beat
  `RRW_ASSERT_NEXT(a_rst_clear, clk, !rst_n, !out_valid)

  // no input taken while a beat is stuck
  `RRW_ASSERT_IMPL(a_in_stall, clk, rst_n, out_valid && !out_ready, !in_ready)

endmodule

bind rtp_rtx_to_original_rewriter rrw_chk u_rrw_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_byte  (out_m.out_byte),
  .out_last  (out_m.out_last),
  .run_end   (out_m.run_end),
  .in_ready  (in_s.ready)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rrw_pkg::*;

  localparam int STORE_DEPTH = 16 + 4 * MAX_EXT_WORDS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_FID_PAIR1 = CFG_FID_PAIR0 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FID_PAIR2 = CFG_FID_PAIR0 + 3'd2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       run_end;
    logic       rewritten;
  } beat_t;

  class rewrite_scoreboard;
    typedef enum {ST_START, ST_HDR, ST_EXTHDR, ST_EXT, ST_OSN, ST_PASS, ST_PASS_RW} parse_e;

    logic [59:0] apt_map;
    logic [63:0] fid_pair [4];
    logic [2:0]  fid_count;
    logic [7:0]  hdr [STORE_DEPTH];
    int unsigned pos;
    parse_e      ph;
    logic [15:0] ext_words;
    logic [38:0] match;
    logic [15:0] osn;
    beat_t       pending [$];
    int          errors;

    function new();
      apt_map = '0;
      foreach (fid_pair[i]) fid_pair[i] = '0;
      fid_count = '0;
      foreach (hdr[i]) hdr[i] = '0;
      pos = 0;
      ph = ST_START;
      ext_words = '0;
      match = '0;
      osn = '0;
      errors = 0;
    endfunction

    function void note_config(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CFG_APT_MAP:   apt_map = data[59:0];
        CFG_FID_PAIR0: fid_pair[0] = data;
        CFG_FID_PAIR1: fid_pair[1] = data;
        CFG_FID_PAIR2: fid_pair[2] = data;
        CFG_FID_PAIR3: fid_pair[3] = data;
        CFG_FID_COUNT: fid_count = data[2:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [7:0] b, logic l, logic rw);
      beat_t t;
      t = '{data: b, last: l, run_end: 1'b0, rewritten: rw};
      pending.push_back(t);
    endfunction

    function void flush(int unsigned stop, logic l, logic rw);
      for (int unsigned i = 1; i <= stop && i < STORE_DEPTH; i++)
        emit(hdr[i], l && (i == stop), rw);
    endfunction

    function int unsigned hdr_len();
      if (hdr[0][4]) return 16 + 4 * ext_words;
      return 12;
    endfunction

    function logic decide();
      logic [6:0]  pt;
      logic [6:0]  mapped;
      logic [14:0] e;
      logic [31:0] ssrc;
      logic        hit;
      int          lim;
      pt = hdr[1][6:0];
      hit = 1'b0;
      mapped = '0;
      for (int i = 0; i < APT_ENTRIES_DEF; i++) begin
        e = apt_map[15*i +: 15];
        if (!hit && e[14] && e[13:7] == pt) begin
          hit = 1'b1;
          mapped = e[6:0];
        end
      end
      if (!hit) return 1'b0;
      ssrc = {hdr[8], hdr[9], hdr[10], hdr[11]};
      lim = (fid_count > FID_ENTRIES_DEF) ? FID_ENTRIES_DEF : fid_count;
      for (int i = 0; i < lim; i++) begin
        if (fid_pair[i][31:0] == ssrc) begin
          match = {mapped, fid_pair[i][63:32]};
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_input(logic [7:0] b, logic l);
      int unsigned p;
      int unsigned hl;
      logic [15:0] w;
      int          start;
      beat_t       t;
      start = pending.size();
      case (ph)
        ST_HDR, ST_EXTHDR, ST_EXT: begin
          p = pos;
          if (p >= STORE_DEPTH) p = STORE_DEPTH - 1;
          hdr[p] = b;
          if (l) begin
            flush(p, 1'b1, 1'b0);
          end else begin
            if (ph == ST_HDR) begin
              if (p == 1 && b >= RTCP_PT_LO && b <= RTCP_PT_HI) begin
                flush(1, 1'b0, 1'b0);
                ph = ST_PASS;
              end else if (p == 11) begin
                if (decide()) begin
                  ph = hdr[0][4] ? ST_EXTHDR : ST_OSN;
                end else begin
                  flush(11, 1'b0, 1'b0);
                  ph = ST_PASS;
                end
              end
            end else if (ph == ST_EXTHDR) begin
              if (p == 15) begin
                w = {hdr[14], hdr[15]};
                if (w > MAX_EXT_WORDS_DEF) begin
                  flush(15, 1'b0, 1'b0);
                  ph = ST_PASS;
                end else begin
                  ext_words = w;
                  ph = (w == 0) ? ST_OSN : ST_EXT;
                end
              end
            end else if (p >= 15 + 4 * ext_words) begin
              ph = ST_OSN;
            end
            pos = p + 1;
          end
        end
        ST_OSN: begin
          hl = hdr_len();
          if (pos == hl) begin
            osn = {b, 8'h00};
            if (l) begin
              flush(hl - 1, 1'b0, 1'b0);
              emit(b, 1'b1, 1'b0);
            end else begin
              pos = pos + 1;
            end
          end else begin
            osn[7:0] = b;
            hdr[1] = {hdr[1][7], match[38:32]};
            hdr[2] = osn[15:8];
            hdr[3] = osn[7:0];
            hdr[8] = match[31:24];
            hdr[9] = match[23:16];
            hdr[10] = match[15:8];
            hdr[11] = match[7:0];
            flush(hl - 1, l, 1'b1);
            ph = ST_PASS_RW;
          end
        end
        ST_PASS, ST_PASS_RW: emit(b, l, ph == ST_PASS_RW);
        default: begin
          hdr[0] = b;
          emit(b, l, 1'b0);
          ext_words = '0;
          ph = ST_HDR;
          pos = 1;
        end
      endcase
      if (l) begin
        ph = ST_START;
        pos = 0;
      end
      if (pending.size() > start) begin
        t = pending.pop_back();
        t.run_end = 1'b1;
        pending.push_back(t);
      end
    endfunction

    function void check_result(beat_t got);
      beat_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat: out_byte %0h", got.data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data) begin
        $error("out_byte expected %0h actual %0h", want.data, got.data);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("out_last expected %0b actual %0b", want.last, got.last);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end expected %0b actual %0b", want.run_end, got.run_end);
        errors++;
      end
      if (got.rewritten !== want.rewritten) begin
        $error("rewritten expected %0b actual %0b", want.rewritten, got.rewritten);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  logic [59:0] apt_cfg = '0;
  logic [63:0] fid_cfg [4] = '{default: '0};

  rewrite_scoreboard sb = new();

  rrw_in_if  in_if ();
  rrw_out_if out_if ();
  rrw_cfg_if cfg_if ();

  rtp_rtx_to_original_rewriter u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if),
    .cfg_s (cfg_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
      @(negedge clk);
      if (out_if.valid && out_if.ready)
        sb.check_result('{data: out_if.out_byte, last: out_if.out_last,
                          run_end: out_if.run_end, rewritten: out_if.rewritten});
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    forever begin
      @(negedge clk);
      if (cfg_if.ready) begin
        sb.note_config(idx, data);
        if (idx == CFG_APT_MAP) apt_cfg = data[59:0];
        else if (idx >= CFG_FID_PAIR0 && idx <= CFG_FID_PAIR3) fid_cfg[idx - CFG_FID_PAIR0] = data;
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic load_config(input logic [59:0] apt, input logic [2:0] count, input bit ones);
    write_reg(CFG_APT_MAP, {4'h0, apt});
    for (int i = 0; i < 4; i++)
      write_reg(CFG_FID_PAIR0 + i[2:0], ones ? {64{1'b1}} : {$urandom, $urandom});
    write_reg(CFG_FID_COUNT, {61'd0, count});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= l;
    forever begin
      @(negedge clk);
      if (in_if.ready) begin
        sb.note_input(b, l);
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic send_packet(input logic [7:0] pk [$]);
    foreach (pk[i]) send_byte(pk[i], i == pk.size() - 1);
  endtask

  // ext_len < 0: no extension; cut > 0: truncate to that many bytes
  task automatic make_rtx(input int entry, input int pair, input int ext_len,
                          input int payload, input int cut, ref logic [7:0] pk [$]);
    logic [7:0]  b0;
    logic [31:0] ssrc;
    pk.delete();
    b0 = $urandom_range(0, 255);
    b0[4] = (ext_len >= 0);
    pk.push_back(b0);
    pk.push_back({$urandom_range(0, 1) == 1, apt_cfg[15*entry + 7 +: 7]});
    repeat (6) pk.push_back($urandom_range(0, 255));
    ssrc = (pair < 4) ? fid_cfg[pair][31:0] : $urandom;
    for (int i = 3; i >= 0; i--) pk.push_back(ssrc[8*i +: 8]);
    if (ext_len >= 0) begin
      pk.push_back($urandom_range(0, 255));
      pk.push_back($urandom_range(0, 255));
      pk.push_back(ext_len[15:8]);
      pk.push_back(ext_len[7:0]);
      repeat (4 * ext_len) pk.push_back($urandom_range(0, 255));
    end
    repeat (2 + payload) pk.push_back($urandom_range(0, 255));
    if (cut > 0 && cut < pk.size()) pk = pk[0:cut-1];
  endtask

  task automatic make_plain(input int len, input bit rtcp, ref logic [7:0] pk [$]);
    pk.delete();
    repeat (len) pk.push_back($urandom_range(0, 255));
    if (rtcp && len > 1) pk[1] = $urandom_range(RTCP_PT_LO, RTCP_PT_HI);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int nbytes);
    logic [7:0] pk [$];
    int sent;
    int pick;
    int ext_len;
    sent = 0;
    while (sent < nbytes) begin
      pick = $urandom_range(0, 9);
      ext_len = ($urandom_range(0, 1) == 1) ? $urandom_range(0, MAX_EXT_WORDS_DEF + 2) : -1;
      if (pick <= 6)
        make_rtx($urandom_range(0, 3), $urandom_range(0, 4), ext_len, $urandom_range(0, 8), 0, pk);
      else if (pick == 7)
        make_rtx($urandom_range(0, 3), $urandom_range(0, 3), ext_len, 0,
                 $urandom_range(1, 20), pk);
      else
        make_plain($urandom_range(1, 20), pick == 8, pk);
      send_packet(pk);
      sent += pk.size();
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] pk [$];
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.in_byte <= '0;
    in_if.in_last <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 28;
    out_idle_pct = 71;
    // entries: 97->96, 99->98, invalid 101, 127->0
    load_config({1'b1, 7'd127, 7'd0, 1'b0, 7'd101, 7'd100,
                 1'b1, 7'd99, 7'd98, 1'b1, 7'd97, 7'd96}, 3'd4, 1'b0);
    make_plain(1, 0, pk);                    send_packet(pk);
    make_plain(4, 1, pk);                    send_packet(pk);
    make_rtx(0, 0, -1, 1, 0, pk);            send_packet(pk);
    make_rtx(3, 3, 0, 0, 0, pk);             send_packet(pk);
    make_rtx(0, 2, MAX_EXT_WORDS_DEF, 0, 0, pk); send_packet(pk);
    make_rtx(1, 0, MAX_EXT_WORDS_DEF + 1, 0, 18, pk); send_packet(pk);
    make_rtx(0, 1, -1, 0, 0, pk);            send_packet(pk);
    make_rtx(1, 2, -1, 3, 13, pk);           send_packet(pk);
    make_rtx(3, 0, 1, 3, 6, pk);             send_packet(pk);
    in_if.valid <= 1'b0;
    drain();

    in_idle_pct = 71;
    out_idle_pct = 28;
    load_config({$urandom, $urandom} | 60'h4000_0000_0000_000, 3'd7, 1'b0);
    run_random(15);
    drain();

    in_idle_pct = 0;
    out_idle_pct = 0;
    load_config({60{1'b1}}, 3'd1, 1'b1);
    run_random(10);
    drain();

    load_config({1'b1, 7'($urandom), 7'($urandom), 1'b1, 7'($urandom), 7'($urandom),
                 1'b1, 7'($urandom), 7'($urandom), 1'b1, 7'($urandom), 7'($urandom)},
                3'd3, 1'b0);
    hold_req = 1'b1;
    run_random(15);
    drain();

    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
